/* design/fpa_pkg.sv */
// Shared opcode type for the fixed-point ALU.
`default_nettype none
package fpa_pkg;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_INC      = 4'd10,
    OP_DEC      = 4'd11,
    OP_MIN      = 4'd12,
    OP_MAX      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } op_e;

endpackage
`default_nettype wire

/* design/fpa_req_if.sv */
// Request channel interface: opcode and two operands.
`default_nettype none
interface fpa_req_if #(
  parameter int DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  fpa_pkg::op_e          req_type;
  logic [DATA_WIDTH-1:0] operand_a;
  logic [DATA_WIDTH-1:0] operand_b;

  modport source (output valid, output req_type, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input req_type, input operand_a, input operand_b,
                output ready);
endinterface
`default_nettype wire

/* design/fpa_rsp_if.sv */
// Response channel interface: raw result and flags.
`default_nettype none
interface fpa_rsp_if #(
  parameter int DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] result_raw;
  logic                  compare_true;
  logic                  divide_error;

  modport source (output valid, output result_raw, output compare_true,
                  output divide_error, input ready);
  modport sink (input valid, input result_raw, input compare_true,
                input divide_error, output ready);
endinterface
`default_nettype wire

/* design/fpa_prep.sv */
// Entry decode: results of the operations that need no chain cell, and setup of the multiply and divide chain.
`default_nettype none
module fpa_prep #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  fpa_pkg::op_e                            op_i,
  input  logic [DATA_WIDTH-1:0]                   a_i,
  input  logic [DATA_WIDTH-1:0]                   b_i,
  output logic [4+3+4*DATA_WIDTH+2*FRAC_BITS-1:0] stage_o
);
  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int AW = W + F;

  typedef struct packed {
    fpa_pkg::op_e  op;
    logic          neg;
    logic          derr;
    logic          cmp;
    logic [AW-1:0] mcand;
    logic [W-1:0]  opb;
    logic [W-1:0]  rem;
    logic [AW-1:0] acc;
  } stage_t;

  stage_t        st;
  logic          gt;
  logic          lt;
  logic [W-1:0]  res;
  logic [W-1:0]  ua;
  logic [W-1:0]  ub;

  assign gt = $signed(a_i) > $signed(b_i);
  assign lt = $signed(a_i) < $signed(b_i);
  assign ua = a_i[W-1] ? (~a_i + W'(1)) : a_i;
  assign ub = b_i[W-1] ? (~b_i + W'(1)) : b_i;

  always_comb begin
    res      = '0;
    st       = '0;
    st.op    = op_i;
    st.mcand = {{F{a_i[W-1]}}, a_i};
    st.opb   = b_i;
    case (op_i)
      fpa_pkg::OP_ADD:      res = a_i + b_i;
      fpa_pkg::OP_SUB:      res = a_i - b_i;
      fpa_pkg::OP_INC:      res = a_i + W'(1);
      fpa_pkg::OP_DEC:      res = a_i - W'(1);
      fpa_pkg::OP_MIN:      res = gt ? b_i : a_i;
      fpa_pkg::OP_MAX:      res = gt ? a_i : b_i;
      fpa_pkg::OP_FROM_INT: res = a_i << F;
      fpa_pkg::OP_TO_INT:   res = W'($signed(a_i) >>> F);
      fpa_pkg::OP_GT:       st.cmp = gt;
      fpa_pkg::OP_LT:       st.cmp = lt;
      fpa_pkg::OP_GE:       st.cmp = !lt;
      fpa_pkg::OP_LE:       st.cmp = !gt;
      fpa_pkg::OP_EQ:       st.cmp = (a_i == b_i);
      fpa_pkg::OP_NE:       st.cmp = (a_i != b_i);
      fpa_pkg::OP_DIV: begin
        st.opb  = ub;
        st.neg  = a_i[W-1] ^ b_i[W-1];
        st.derr = (b_i == '0);
      end
      default: ;
    endcase
    if (op_i == fpa_pkg::OP_DIV) begin
      st.acc = {ua, {F{1'b0}}};
    end else if (op_i == fpa_pkg::OP_MUL) begin
      st.acc = '0;
    end else begin
      st.acc = {{F{1'b0}}, res};
    end
  end

  assign stage_o = st;
endmodule
`default_nettype wire

/* design/fpa_cell.sv */
// One chain cell: a shift-add multiply step and a restoring divide step.
`default_nettype none
module fpa_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 8,
  parameter int IDX        = 0
) (
  input  logic [4+3+4*DATA_WIDTH+2*FRAC_BITS-1:0] stage_i,
  output logic [4+3+4*DATA_WIDTH+2*FRAC_BITS-1:0] stage_o
);
  localparam int W        = DATA_WIDTH;
  localparam int F        = FRAC_BITS;
  localparam int AW       = W + F;
  localparam bit MUL_CELL = (IDX < W);
  localparam int BIT      = MUL_CELL ? IDX : 0;

  typedef struct packed {
    fpa_pkg::op_e  op;
    logic          neg;
    logic          derr;
    logic          cmp;
    logic [AW-1:0] mcand;
    logic [W-1:0]  opb;
    logic [W-1:0]  rem;
    logic [AW-1:0] acc;
  } stage_t;

  stage_t        si;
  stage_t        so;
  logic [AW-1:0] addend;
  logic [W:0]    rem_sh;
  logic [W:0]    diff;

  assign si     = stage_i;
  assign addend = si.mcand << BIT;
  assign rem_sh = {si.rem, si.acc[AW-1]};
  assign diff   = rem_sh - {1'b0, si.opb};

  always_comb begin
    so = si;
    case (si.op)
      fpa_pkg::OP_MUL: begin
        if (MUL_CELL && si.opb[BIT]) begin
          so.acc = (BIT == W - 1) ? (si.acc - addend) : (si.acc + addend);
        end
      end
      fpa_pkg::OP_DIV: begin
        if (!diff[W]) begin
          so.rem = diff[W-1:0];
          so.acc = {si.acc[AW-2:0], 1'b1};
        end else begin
          so.rem = rem_sh[W-1:0];
          so.acc = {si.acc[AW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign stage_o = so;
endmodule
`default_nettype wire

/* design/fpa_out.sv */
// Result selection and the two-entry output buffer.
`default_nettype none
module fpa_out #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     vld_i,
  input  logic [4+3+4*DATA_WIDTH+2*FRAC_BITS-1:0]  stage_i,
  output logic                                     adv_o,
  fpa_rsp_if.source                                rsp_o
);
  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int AW = W + F;

  typedef struct packed {
    fpa_pkg::op_e  op;
    logic          neg;
    logic          derr;
    logic          cmp;
    logic [AW-1:0] mcand;
    logic [W-1:0]  opb;
    logic [W-1:0]  rem;
    logic [AW-1:0] acc;
  } stage_t;

  typedef struct packed {
    logic [W-1:0] result;
    logic         cmp;
    logic         derr;
  } beat_t;

  stage_t st;
  beat_t  beat;
  beat_t  out_q;
  beat_t  out_d;
  beat_t  skid_q;
  beat_t  skid_d;
  logic   out_vld_q;
  logic   out_vld_d;
  logic   skid_vld_q;
  logic   skid_vld_d;
  logic   take;

  assign st = stage_i;

  always_comb begin
    beat.cmp  = st.cmp;
    beat.derr = st.derr;
    case (st.op)
      fpa_pkg::OP_MUL: beat.result = st.acc[AW-1:F];
      fpa_pkg::OP_DIV: begin
        if (st.derr) begin
          beat.result = '0;
        end else if (st.neg) begin
          beat.result = ~st.acc[W-1:0] + W'(1);
        end else begin
          beat.result = st.acc[W-1:0];
        end
      end
      default: beat.result = st.acc[W-1:0];
    endcase
  end

  assign adv_o = !skid_vld_q;
  assign take  = vld_i && !skid_vld_q;

  always_comb begin
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    skid_d     = skid_q;
    skid_vld_d = skid_vld_q;
    if (!out_vld_q || rsp_o.ready) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end else begin
        out_d     = beat;
        out_vld_d = take;
      end
    end else if (take) begin
      skid_d     = beat;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.result_raw   = out_q.result;
  assign rsp_o.compare_true = out_q.cmp;
  assign rsp_o.divide_error = out_q.derr;
endmodule
`default_nettype wire

/* design/fixed_point_alu.sv */
// Top level of the pipelined signed fixed-point ALU.
//
//   Channel  Dir  Payload                                   Handshake
//   req_i    in   req_type, operand_a, operand_b            valid/ready
//   rsp_o    out  result_raw, compare_true, divide_error    valid/ready
//
// One beat is accepted per cycle while ready is high; each passes through the cell
// chain, which retires one quotient bit per cell (or, in the multiply cells, one
// multiplier bit per cell).
// Reset clears the stage valid bits and the valid bits of the output buffer.
// A two-entry output buffer holds results during a stall; ready drops only when
// its second entry is occupied, and the whole chain then holds.
`default_nettype none
module fixed_point_alu #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fpa_req_if.sink   req_i,
  fpa_rsp_if.source rsp_o
);
  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int AW = W + F;
  localparam int L  = W + F;

  typedef struct packed {
    fpa_pkg::op_e  op;
    logic          neg;
    logic          derr;
    logic          cmp;
    logic [AW-1:0] mcand;
    logic [W-1:0]  opb;
    logic [W-1:0]  rem;
    logic [AW-1:0] acc;
  } stage_t;

  stage_t         stage_q [L+1];
  stage_t         stage_d [L+1];
  logic [L:0]     vld_q;
  logic           adv;

  fpa_prep #(
    .DATA_WIDTH(W),
    .FRAC_BITS (F)
  ) u_prep (
    .op_i   (req_i.req_type),
    .a_i    (req_i.operand_a),
    .b_i    (req_i.operand_b),
    .stage_o(stage_d[0])
  );

  for (genvar i = 0; i < L; i++) begin : g_cell
    fpa_cell #(
      .DATA_WIDTH(W),
      .FRAC_BITS (F),
      .IDX       (i)
    ) u_cell (
      .stage_i(stage_q[i]),
      .stage_o(stage_d[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[L-1:0], req_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i <= L; i++) begin
        stage_q[i] <= stage_d[i];
      end
    end
  end

  assign req_i.ready = adv;

  fpa_out #(
    .DATA_WIDTH(W),
    .FRAC_BITS (F)
  ) u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld_q[L]),
    .stage_i(stage_q[L]),
    .adv_o  (adv),
    .rsp_o  (rsp_o)
  );
endmodule
`default_nettype wire

/* design/fpa_checker.sv */
// Port-level checks on the ALU response channel, bound to the top level.
`default_nettype none
module fpa_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  rsp_valid_i,
  input logic                  rsp_ready_i,
  input logic [DATA_WIDTH-1:0] result_raw_i,
  input logic                  compare_true_i,
  input logic                  divide_error_i
);

  a_flags_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(compare_true_i && divide_error_i))
    else $error("Compare and divide flags are both set.");

  a_div_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && divide_error_i) |-> (result_raw_i == '0))
    else $error("Division by zero gave a nonzero result.");

  a_cmp_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && compare_true_i) |-> (result_raw_i == '0))
    else $error("A comparison gave a nonzero result.");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(result_raw_i)
      && $stable(compare_true_i) && $stable(divide_error_i)))
    else $error("A stalled response beat changed.");

endmodule

bind fixed_point_alu fpa_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_fpa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .result_raw_i  (rsp_o.result_raw),
  .compare_true_i(rsp_o.compare_true),
  .divide_error_i(rsp_o.divide_error)
);
`default_nettype wire
